// ----- rtl/sha1md_pkg.sv -----
`timescale 1ns / 1ps
package sha1md_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned RoundW   = 7;
  localparam int unsigned LastRound = 79;

  typedef logic [WordW-1:0] word_t;

  // a..e of the round function, or h0..h4 of the chaining value
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } vars_t;

  localparam vars_t InitChain = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476,
    e: 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam word_t PadMarker = 32'h80000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

endpackage

// ----- rtl/sha1_message_digest_core.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Fields (tdata low bit up / tlast)
// s_axis    in   data_word[31:0], byte_count[34:32] / final_word
// m_axis    out  digest_word[31:0], word_index[34:32] / last_result
//
// A message word is taken on each accepted input item. The 16th word of a block
// starts the compression: the rounds run through the single round unit, then
// the chaining add is done in ST_ADD. The final word adds padding words at
// one per cycle (one or two blocks), pausing while a full block is compressed,
// then the five digest words leave one per accepted output item. s_axis
// is not ready while padding, compressing or emitting. Reset loads the SHA-1
// initial chaining value and clears all control state.
module sha1_message_digest_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // data_word[31:0], byte_count[34:32], zero pad
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero pad
  output logic        m_axis_tlast
);
  import sha1md_pkg::*;

  state_e state_q, state_d;

  logic [3:0]        fill_q;
  logic [RoundW-1:0] rnd_q;
  logic [63:0]       bit_len_q;
  logic [2:0]        out_idx_q;
  logic              pad_q;
  logic              marker_q;
  logic              len_hi_q;
  logic              len_done_q;

  vars_t chain_q;
  vars_t work_q;
  vars_t round_out;
  word_t win_q [16];
  word_t sched_next;

  logic  in_acc;
  logic  out_acc;
  logic  push_en;
  logic  push_full;
  word_t push_word;

  word_t      in_word;
  logic [2:0] in_bc;
  logic [2:0] bc_sat;
  word_t      final_word;
  logic [5:0] len_inc;
  word_t      digest_sel;

  assign in_word = s_axis_tdata[31:0];
  assign in_bc   = s_axis_tdata[34:32];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign bc_sat = (in_bc > 3'd4) ? 3'd4 : in_bc;

  // last word with bytes past the valid ones cleared; the marker is appended when fewer than four bytes are valid
  always_comb begin
    unique case (bc_sat)
      3'd0:    final_word = PadMarker;
      3'd1:    final_word = {in_word[31:24], 24'h800000};
      3'd2:    final_word = {in_word[31:16], 16'h8000};
      3'd3:    final_word = {in_word[31:8], 8'h80};
      default: final_word = in_word;
    endcase
  end

  assign len_inc   = s_axis_tlast ? {bc_sat, 3'b000} : 6'd32;
  assign push_full = push_en && (fill_q == 4'd15);

  // window holds W[r]..W[r+15]; W[r] sits at entry 0
  assign sched_next = {win_q[13][30:0] ^ win_q[8][30:0] ^ win_q[2][30:0] ^ win_q[0][30:0],
                       win_q[13][31] ^ win_q[8][31] ^ win_q[2][31] ^ win_q[0][31]};

  sha1md_round u_round (
    .rnd_i  (rnd_q),
    .w_i    (win_q[0]),
    .vars_i (work_q),
    .vars_o (round_out)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (push_full) begin
            state_d = ST_ROUND;
          end else if (s_axis_tlast) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (push_full) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_q == RoundW'(LastRound)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (len_done_q) begin
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc && out_idx_q == 3'd4) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    push_en       = 1'b0;
    push_word     = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        push_en       = in_acc;
        push_word     = s_axis_tlast ? final_word : in_word;
      end
      ST_PAD: begin
        push_en = 1'b1;
        priority if (marker_q) begin
          push_word = PadMarker;
        end else if (len_hi_q) begin
          push_word = bit_len_q[31:0];
        end else if (fill_q == 4'd14) begin
          push_word = bit_len_q[63:32];
        end else begin
          push_word = '0;
        end
      end
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (out_idx_q)
      3'd0:    digest_sel = chain_q.a;
      3'd1:    digest_sel = chain_q.b;
      3'd2:    digest_sel = chain_q.c;
      3'd3:    digest_sel = chain_q.d;
      default: digest_sel = chain_q.e;
    endcase
  end
  assign m_axis_tdata = {5'b0, out_idx_q, digest_sel};
  assign m_axis_tlast = (out_idx_q == 3'd4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      rnd_q      <= '0;
      bit_len_q  <= '0;
      out_idx_q  <= '0;
      pad_q      <= 1'b0;
      marker_q   <= 1'b0;
      len_hi_q   <= 1'b0;
      len_done_q <= 1'b0;
      chain_q    <= InitChain;
    end else begin
      state_q <= state_d;
      if (push_en) begin
        fill_q <= fill_q + 4'd1;
      end
      if (in_acc) begin
        bit_len_q <= bit_len_q + 64'(len_inc);
        if (s_axis_tlast) begin
          pad_q    <= 1'b1;
          marker_q <= (bc_sat == 3'd4);
        end
      end
      if (state_q == ST_PAD) begin
        priority if (marker_q) begin
          marker_q <= 1'b0;
        end else if (len_hi_q) begin
          len_done_q <= 1'b1;
        end else if (fill_q == 4'd14) begin
          len_hi_q <= 1'b1;
        end
      end
      if (state_q == ST_ROUND) begin
        rnd_q <= (rnd_q == RoundW'(LastRound)) ? '0 : rnd_q + RoundW'(1);
      end
      if (state_q == ST_ADD) begin
        chain_q.a <= chain_q.a + work_q.a;
        chain_q.b <= chain_q.b + work_q.b;
        chain_q.c <= chain_q.c + work_q.c;
        chain_q.d <= chain_q.d + work_q.d;
        chain_q.e <= chain_q.e + work_q.e;
      end
      if (out_acc) begin
        if (out_idx_q == 3'd4) begin
          // digest delivered: fresh message
          out_idx_q  <= '0;
          fill_q     <= '0;
          bit_len_q  <= '0;
          pad_q      <= 1'b0;
          marker_q   <= 1'b0;
          len_hi_q   <= 1'b0;
          len_done_q <= 1'b0;
          chain_q    <= InitChain;
        end else begin
          out_idx_q <= out_idx_q + 3'd1;
        end
      end
    end
  end

  // payload: message schedule window and round variables
  always_ff @(posedge clk_i) begin
    if (push_en || state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= push_en ? push_word : sched_next;
    end
    if (push_full) begin
      work_q <= chain_q;
    end else if (state_q == ST_ROUND) begin
      work_q <= round_out;
    end
  end

endmodule

// ----- rtl/sha1md_round.sv -----
`timescale 1ns / 1ps
module sha1md_round (
  input  logic [sha1md_pkg::RoundW-1:0] rnd_i,
  input  sha1md_pkg::word_t             w_i,
  input  sha1md_pkg::vars_t             vars_i,
  output sha1md_pkg::vars_t             vars_o
);
  import sha1md_pkg::*;

  word_t f;
  word_t k;
  word_t t;

  always_comb begin
    priority if (rnd_i < RoundW'(20)) begin
      f = (vars_i.b & vars_i.c) | (~vars_i.b & vars_i.d);
      k = K0;
    end else if (rnd_i < RoundW'(40)) begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
      k = K1;
    end else if (rnd_i < RoundW'(60)) begin
      f = (vars_i.b & vars_i.c) | (vars_i.b & vars_i.d) | (vars_i.c & vars_i.d);
      k = K2;
    end else begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
      k = K3;
    end
  end

  assign t = {vars_i.a[26:0], vars_i.a[31:27]} + f + vars_i.e + k + w_i;

  assign vars_o.a = t;
  assign vars_o.b = vars_i.a;
  assign vars_o.c = {vars_i.b[1:0], vars_i.b[31:2]};
  assign vars_o.d = vars_i.c;
  assign vars_o.e = vars_i.d;

endmodule

// ----- dv/sha1_message_digest_core_tb.sv -----
`timescale 1ns / 1ps
module sha1_message_digest_core_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned RandomWords = 158;

  localparam logic [31:0] RoundK0 = 32'h5A827999;
  localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RoundK3 = 32'hCA62C1D6;
  localparam logic [31:0] EndMarker = 32'h80000000;
  localparam logic [31:0] ChainInit [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef struct {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        fin;
  } msg_word_t;

  typedef struct {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // data_word[31:0], byte_count[34:32], zero pad
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // digest_word[31:0], word_index[34:32], zero pad
  logic        m_axis_tlast;

  sha1_message_digest_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  msg_word_t    word_feed_q[$];
  digest_word_t digest_q[$];

  // running hash state of the message in flight
  logic [31:0] chain_h [5];
  logic [31:0] block_w [16];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  int unsigned err_count = 0;
  int unsigned digests_seen = 0;
  int unsigned cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic clear_hash;
    for (int i = 0; i < 5; i++) chain_h[i] = ChainInit[i];
    for (int i = 0; i < 16; i++) block_w[i] = '0;
    block_fill = 0;
    msg_bits = '0;
  endtask

  task automatic compress_block;
    logic [31:0] a, b, c, d, e, f, k, t, w;
    logic [31:0] ws [16];
    ws = block_w;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w = ws[(r - 3) & 15] ^ ws[(r - 8) & 15] ^ ws[(r - 14) & 15] ^ ws[r & 15];
        w = {w[30:0], w[31]};
        ws[r & 15] = w;
      end else begin
        w = ws[r];
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RoundK0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RoundK1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RoundK2;
      end else begin
        f = b ^ c ^ d;
        k = RoundK3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endtask

  task automatic absorb_word(input logic [31:0] w);
    block_w[block_fill] = w;
    block_fill++;
    if (block_fill == 16) begin
      compress_block();
      block_fill = 0;
    end
  endtask

  // advance the hash by one accepted item; a final item queues the digest
  task automatic hash_word(input msg_word_t it);
    int unsigned nb;
    logic [31:0] mask;
    if (!it.fin) begin
      msg_bits += 64'd32;
      absorb_word(it.data);
    end else begin
      nb = (it.nbytes > 3'd4) ? 4 : it.nbytes;
      msg_bits += 64'(8 * nb);
      if (nb == 4) begin
        absorb_word(it.data);
        absorb_word(EndMarker);
      end else begin
        mask = '1;
        mask = (nb == 0) ? '0 : (mask << (32 - 8 * nb));
        absorb_word((it.data & mask) | (EndMarker >> (8 * nb)));
      end
      while (block_fill != 14) absorb_word('0);
      absorb_word(msg_bits[63:32]);
      absorb_word(msg_bits[31:0]);
      for (int i = 0; i < 5; i++)
        digest_q.push_back('{digest: chain_h[i], index: 3'(i), last: (i == 4)});
      clear_hash();
    end
  endtask

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_word(input logic [31:0] data, input logic [2:0] nb, input logic fin);
    word_feed_q.push_back('{data: data, nbytes: nb, fin: fin});
  endtask

  // len words in all; byte count on the non-final words is noise
  task automatic queue_message(input int unsigned len, input logic [2:0] last_nb);
    for (int unsigned i = 1; i < len; i++)
      queue_word(pick_data(), 3'($urandom_range(0, 7)), 1'b0);
    queue_word(pick_data(), last_nb, 1'b1);
  endtask

  // sender: bursts of items with random gaps, holding each offer until taken
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      burst_left = $urandom_range(1, 20);
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        hash_word(word_feed_q[0]);
        void'(word_feed_q.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (word_feed_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {5'b0, word_feed_q[0].nbytes, word_feed_q[0].data};
          s_axis_tlast <= word_feed_q[0].fin;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: mode changes with the top bits of rx_phase, plus two long hold-offs mid-digest
  logic [7:0] rx_phase;
  int         hold_left;
  int         holds_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_phase = '0;
      hold_left = 0;
      holds_done = 0;
    end else begin
      rx_phase++;
      if (hold_left == 0 && ((holds_done == 0 && digests_seen >= 12) ||
                             (holds_done == 1 && digests_seen >= 63))) begin
        hold_left = 400;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_phase[7:6])
          2'd0: m_axis_tready <= 1'b1;
          2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= rx_phase[2];
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : digest_check
    digest_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest item: digest_word %h word_index %0d last_result %0b",
               m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
        err_count++;
      end else begin
        want = digest_q.pop_front();
        digests_seen++;
        if (m_axis_tdata[31:0] !== want.digest) begin
          $error("digest_word: expected %h, got %h", want.digest, m_axis_tdata[31:0]);
          err_count++;
        end
        if (m_axis_tdata[34:32] !== want.index) begin
          $error("word_index: expected %0d, got %0d", want.index, m_axis_tdata[34:32]);
          err_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_result: expected %0b, got %0b", want.last, m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned rand_words;
    int unsigned len;
    logic [2:0]  nb;
    clear_hash();

    // one-word messages over every byte count, saturating counts too
    queue_word(32'h12345678, 3'd0, 1'b1);
    queue_word(32'h61626300, 3'd3, 1'b1);
    queue_word(32'hFFFFFFFF, 3'd4, 1'b1);
    queue_word(32'h00000000, 3'd7, 1'b1);
    queue_word(32'hFFFFFFFF, 3'd1, 1'b1);
    queue_word(32'hFFFFFFFF, 3'd2, 1'b1);
    queue_word($urandom, 3'd5, 1'b1);
    queue_word($urandom, 3'd6, 1'b1);
    // 14 words ending in four bytes: marker lands at the 15th slot, so the
    // length spills into an extra block
    queue_word(32'hFFFFFFFF, 3'd7, 1'b0);
    queue_word(32'h00000000, 3'd0, 1'b0);
    for (int i = 0; i < 11; i++) queue_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
    queue_word(32'hA5A5A5A5, 3'd4, 1'b1);

    rand_words = 0;
    while (rand_words < RandomWords) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(1, 4);
        1: len = $urandom_range(12, 17);
        2: len = $urandom_range(28, 33);
        default: len = $urandom_range(5, 11);
      endcase
      nb = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
                                       : 3'($urandom_range(0, 4));
      queue_message(len, nb);
      rand_words += len;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_feed_q.size() != 0 || digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
